FILE: hw/rtl/clfr_pkg.sv
// Shared types, constants and status codes of the CR LF length frame receiver.
`default_nettype none

package clfr_pkg;

    // Field widths
    localparam int unsigned CountW = 12;
    localparam int unsigned LenW   = 16;
    localparam int unsigned IdleW  = 8;
    localparam int unsigned ByteW  = 8;
    localparam int unsigned StatW  = 3;
    localparam int unsigned CodeW  = 7;

    // Configuration port
    localparam int unsigned AddrW  = 3;
    localparam int unsigned DataW  = 32;

    // Register reset values
    localparam logic [CountW-1:0] MaxFrameReset  = 12'd768;
    localparam logic [IdleW-1:0]  IdleLimitReset = 8'd10;

    // Register indexes (taken from paddr[2])
    localparam logic RegMaxFrame  = 1'b0;
    localparam logic RegIdleLimit = 1'b1;

    // Trailer characters and command byte masks
    localparam logic [ByteW-1:0] AsciiCr  = 8'h0d;
    localparam logic [ByteW-1:0] AsciiLf  = 8'h0a;
    localparam int unsigned      RespBit  = 7;
    localparam logic [CodeW-1:0] CmdData  = 7'd1;

    // Item kinds
    localparam logic ReqByte = 1'b0;
    localparam logic ReqIdle = 1'b1;

    // Event status codes
    localparam logic [StatW-1:0] StInFrame  = 3'd0;
    localparam logic [StatW-1:0] StComplete = 3'd1;
    localparam logic [StatW-1:0] StLenError = 3'd2;
    localparam logic [StatW-1:0] StOverflow = 3'd3;
    localparam logic [StatW-1:0] StTimeout  = 3'd4;
    localparam logic [StatW-1:0] StIdle     = 3'd5;

    typedef struct packed {
        logic             req_type;
        logic [ByteW-1:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [ByteW-1:0]  byte_out;
        logic [CountW-1:0] byte_index;
        logic [StatW-1:0]  event_status;
        logic [LenW-1:0]   frame_length;
        logic [CodeW-1:0]  command_code;
        logic              is_response;
        logic              command_known;
        logic [ByteW-1:0]  order_number;
    } out_item_t;

    typedef struct packed {
        logic [CountW-1:0] max_frame_bytes;
        logic [IdleW-1:0]  idle_limit;
    } cfg_t;

endpackage

`default_nettype wire

FILE: hw/rtl/clfr_apb_regs.sv
// APB configuration registers: receive size limit and idle tick limit.
`default_nettype none

module clfr_apb_regs
    import clfr_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [AddrW-1:0] paddr,
    input  wire logic [DataW-1:0] pwdata,
    output logic      [DataW-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    // Decode the write
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (paddr[2])
                RegMaxFrame:  cfg_next.max_frame_bytes = pwdata[CountW-1:0];
                RegIdleLimit: cfg_next.idle_limit      = pwdata[IdleW-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_frame_bytes <= MaxFrameReset;
            cfg_reg.idle_limit      <= IdleLimitReset;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back
    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            RegMaxFrame:  prdata = {{(DataW-CountW){1'b0}}, cfg_reg.max_frame_bytes};
            RegIdleLimit: prdata = {{(DataW-IdleW){1'b0}}, cfg_reg.idle_limit};
            default:      prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/clfr_deframer.sv
// Frame state registers and the per-item deframing and check logic.
`default_nettype none

module clfr_deframer
    import clfr_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     advance,
    input  wire in_item_t item,
    input  wire cfg_t     cfg,
    output out_item_t     result
);

    logic [CountW-1:0] byte_count_reg, byte_count_next;
    logic [LenW-1:0]   length_word_reg, length_word_next;
    logic              cr_seen_reg, cr_seen_next;
    logic [IdleW-1:0]  idle_count_reg, idle_count_next;
    logic [ByteW-1:0]  command_byte_reg, command_byte_next;
    logic [ByteW-1:0]  order_byte_reg, order_byte_next;

    logic              frame_start;
    logic [CountW-1:0] count_inc;
    logic [LenW:0]     total;
    logic [LenW:0]     limit_wide;
    logic [LenW:0]     count_wide;
    logic              crlf;
    logic [StatW-1:0]  status;
    logic [ByteW-1:0]  bout;

    assign frame_start = (byte_count_reg == '0);
    assign count_inc   = byte_count_reg + 12'd1;
    assign limit_wide  = {{(LenW+1-CountW){1'b0}}, cfg.max_frame_bytes};
    assign count_wide  = {{(LenW+1-CountW){1'b0}}, count_inc};
    assign total       = {1'b0, length_word_next} + 17'd4;

    // Advance the frame state for one item
    always_comb begin
        byte_count_next   = byte_count_reg;
        length_word_next  = length_word_reg;
        cr_seen_next      = cr_seen_reg;
        idle_count_next   = idle_count_reg;
        command_byte_next = command_byte_reg;
        order_byte_next   = order_byte_reg;
        crlf              = 1'b0;
        status            = StInFrame;
        bout              = '0;

        if (item.req_type == ReqByte) begin
            idle_count_next = '0;
            bout            = item.rx_byte;
            // Clear captured fields at frame start
            if (frame_start) begin
                length_word_next  = '0;
                command_byte_next = '0;
                order_byte_next   = '0;
            end
            // Capture header bytes
            if (byte_count_reg == 12'd0) begin
                length_word_next[ByteW-1:0] = item.rx_byte;
            end else if (byte_count_reg == 12'd1) begin
                length_word_next[LenW-1:ByteW] = item.rx_byte;
            end else if (byte_count_reg == 12'd2) begin
                command_byte_next = item.rx_byte;
            end else if (byte_count_reg == 12'd3) begin
                order_byte_next = item.rx_byte;
            end
            byte_count_next = count_inc;

            crlf         = (item.rx_byte == AsciiLf) && cr_seen_reg && !frame_start;
            cr_seen_next = (item.rx_byte == AsciiCr);

            // Check the trailer; length error before overflow
            priority if (crlf && (total > limit_wide || total < count_wide)) begin
                status = StLenError;
            end else if (crlf && total == count_wide) begin
                status = StComplete;
            end else if (count_inc >= cfg.max_frame_bytes) begin
                status = StOverflow;
            end else begin
                status = StInFrame;
            end

            // End the frame on any final status
            if (status != StInFrame) begin
                byte_count_next = '0;
                cr_seen_next    = 1'b0;
            end
        end else begin
            if (idle_count_reg < cfg.idle_limit) begin
                idle_count_next = idle_count_reg + 8'd1;
                status          = StIdle;
            end else begin
                idle_count_next = '0;
                status          = StTimeout;
                byte_count_next = '0;
                cr_seen_next    = 1'b0;
            end
        end
    end

    // Build the result from the updated captured fields
    always_comb begin
        result.byte_out      = bout;
        result.byte_index    = byte_count_reg;
        result.event_status  = status;
        result.frame_length  = length_word_next;
        result.command_code  = command_byte_next[CodeW-1:0];
        result.is_response   = command_byte_next[RespBit];
        result.command_known = (command_byte_next[CodeW-1:0] <= CmdData);
        result.order_number  = order_byte_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg   <= '0;
            length_word_reg  <= '0;
            cr_seen_reg      <= 1'b0;
            idle_count_reg   <= '0;
            command_byte_reg <= '0;
            order_byte_reg   <= '0;
        end else if (advance) begin
            byte_count_reg   <= byte_count_next;
            length_word_reg  <= length_word_next;
            cr_seen_reg      <= cr_seen_next;
            idle_count_reg   <= idle_count_next;
            command_byte_reg <= command_byte_next;
            order_byte_reg   <= order_byte_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/crlf_length_frame_receiver_core.sv
// Top level of the CR LF length frame receiver: input register, deframer, result register.
//
// Use: each item on the s_ channel is either a received byte (req_type 0) or an
// idle tick (req_type 1). For every item exactly one result comes out on the
// m_ channel: the byte with its index in the frame and an event status (in
// frame, complete, length error, overflow, timeout abort or idle), plus the
// captured length, command and order fields of the current frame.
// Both channels use valid/ready. An item enters the input register, is
// processed by the deframer and lands in the result register that drives m_valid.
// Throughput is one item per cycle while m_ready is high: the frame counters
// are updated by one pass of compare and increment logic, and a new item is
// taken while the previous result is still on the m_ channel.
// When the receiver holds m_ready low, the result register holds, then the
// input register fills, and s_ready drops; no item is lost.
// Reset (aresetn low, synchronous) empties both registers, clears the frame
// state and loads the size limit with 768 and the idle limit with 10.
// The user must write the APB registers only while no item is in flight; this is not enforced.
`default_nettype none

module crlf_length_frame_receiver_core
    import clfr_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    // Input items
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire in_item_t         s_data,
    // Result items
    output logic                  m_valid,
    input  wire logic             m_ready,
    output out_item_t             m_data,
    // Configuration
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [AddrW-1:0] paddr,
    input  wire logic [DataW-1:0] pwdata,
    output logic      [DataW-1:0] prdata,
    output logic                  pready
);

    cfg_t      cfg;
    in_item_t  in_data_reg;
    logic      in_valid_reg;
    out_item_t out_data_reg;
    logic      out_valid_reg;
    out_item_t result;
    logic      advance;

    clfr_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Move the held item to the result register when there is room
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    clfr_deframer u_deframer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_data_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

`default_nettype wire
